// ----- src/gridlod_pkg.sv -----
// Shared types, constants and geometry helpers for the grid LOD index generator.
package gridlod_pkg;

    localparam int MAX_RES   = 256;
    localparam int RES_W     = 9;
    localparam int LVL_W     = 3;
    localparam int MAXLV_W   = 4;
    localparam int CNT_W     = 8;
    localparam int IDX_W     = 17;
    localparam int PART_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RES_X      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_Z      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVELS = 2'd2;

    // Request modes
    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_ADVANCE = 1'b1;

    // Sequencer sections; the first five double as the part code
    localparam logic [PART_W-1:0] SEC_MAIN   = 3'd0;
    localparam logic [PART_W-1:0] SEC_BOTTOM = 3'd1;
    localparam logic [PART_W-1:0] SEC_TOP    = 3'd2;
    localparam logic [PART_W-1:0] SEC_LEFT   = 3'd3;
    localparam logic [PART_W-1:0] SEC_RIGHT  = 3'd4;
    localparam logic [PART_W-1:0] SEC_IDLE   = 3'd5;

    typedef struct packed {
        logic             mode;
        logic [LVL_W-1:0] level;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]  vert_first;
        logic [IDX_W-1:0]  vert_second;
        logic [IDX_W-1:0]  vert_third;
        logic [PART_W-1:0] part;
        logic              final_tri;
    } prim_t;

    // Grid geometry derived from the configuration registers
    typedef struct packed {
        logic [RES_W-1:0] rx;
        logic [RES_W-1:0] rz;
        logic [IDX_W-1:0] mv;
        logic [IDX_W-1:0] top_base;
        logic [IDX_W-1:0] s_top;
        logic [IDX_W-1:0] s_left;
        logic [IDX_W-1:0] s_right;
        logic [LVL_W-1:0] lv_max;
    } geom_t;

    function automatic logic [RES_W-1:0] clamp_res(input logic [RES_W-1:0] r);
        logic [RES_W-1:0] v;
        v = r;
        if (r < RES_W'(2))
            v = RES_W'(2);
        else if (r > RES_W'(MAX_RES))
            v = RES_W'(MAX_RES);
        return v;
    endfunction

    function automatic geom_t make_geom(input logic [RES_W-1:0]   res_x,
                                        input logic [RES_W-1:0]   res_z,
                                        input logic [MAXLV_W-1:0] max_levels);
        geom_t            g;
        logic [RES_W-1:0] m;
        logic [CNT_W-1:0] mm1;
        logic [MAXLV_W-1:0] k;
        logic [MAXLV_W-1:0] lim;
        g.rx       = clamp_res(res_x);
        g.rz       = clamp_res(res_z);
        g.mv       = IDX_W'(g.rx) * IDX_W'(g.rz);
        g.top_base = g.mv - IDX_W'(g.rx);
        g.s_top    = g.mv + IDX_W'(g.rx);
        g.s_left   = g.mv + (IDX_W'(g.rx) << 1);
        g.s_right  = g.mv + (IDX_W'(g.rx) << 1) + IDX_W'(g.rz);
        // ceil(log2(m)) is the bit length of m-1
        m   = (g.rx > g.rz) ? g.rx : g.rz;
        mm1 = CNT_W'(m - RES_W'(1));
        k   = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (mm1[b])
                k = MAXLV_W'(b + 1);
        end
        lim = (max_levels < k) ? max_levels : k;
        if (lim < MAXLV_W'(1))
            lim = MAXLV_W'(1);
        g.lv_max = LVL_W'(lim - MAXLV_W'(1));
        return g;
    endfunction

endpackage

// ----- src/gridlod_cfg.sv -----
// Configuration registers and the registered grid geometry derived from them.
module gridlod_cfg
    import gridlod_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output logic                 cfg_clear,
    output geom_t                geom
);

    localparam geom_t GEOM_RST = make_geom(RES_W'(2), RES_W'(2), MAXLV_W'(1));

    logic [RES_W-1:0]   res_x_reg,      res_x_next;
    logic [RES_W-1:0]   res_z_reg,      res_z_next;
    logic [MAXLV_W-1:0] max_levels_reg, max_levels_next;
    geom_t              geom_reg;

    // A write to any listed register ends a running list
    always_comb
    begin
        cfg_clear = 1'b0;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_RES_X, CFG_RES_Z, CFG_MAX_LEVELS: cfg_clear = 1'b1;
                default:                             cfg_clear = 1'b0;
            endcase
        end
    end

    // Register values after this cycle's write, so the geometry follows at once
    always_comb
    begin
        res_x_next      = res_x_reg;
        res_z_next      = res_z_reg;
        max_levels_next = max_levels_reg;
        if (cfg_valid && cfg_index == CFG_RES_X)
            res_x_next = cfg_data;
        if (cfg_valid && cfg_index == CFG_RES_Z)
            res_z_next = cfg_data;
        if (cfg_valid && cfg_index == CFG_MAX_LEVELS)
            max_levels_next = cfg_data[MAXLV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_x_reg      <= RES_W'(2);
            res_z_reg      <= RES_W'(2);
            max_levels_reg <= MAXLV_W'(1);
            geom_reg       <= GEOM_RST;
        end else begin
            res_x_reg      <= res_x_next;
            res_z_reg      <= res_z_next;
            max_levels_reg <= max_levels_next;
            geom_reg       <= make_geom(res_x_next, res_z_next, max_levels_next);
        end
    end

    assign geom = geom_reg;

endmodule

// ----- src/gridlod_seq.sv -----
// Triangle walk counters and the vertex index arithmetic for the current triangle.
module gridlod_seq
    import gridlod_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  geom_t geom,
    input  logic  cfg_clear,
    input  logic  step_en,
    input  cmd_t  cmd,
    output logic  emits,
    output prim_t prim
);

    logic [LVL_W-1:0]  lvl_reg,     lvl_next;
    logic [PART_W-1:0] section_reg, section_next;
    logic [CNT_W-1:0]  col_reg,     col_next;
    logic [CNT_W-1:0]  row_reg,     row_next;
    logic              half_reg,    half_next;

    logic [LVL_W-1:0]  lv_start;
    logic [RES_W-1:0]  step;
    logic [RES_W-1:0]  step_start;
    logic [CNT_W-1:0]  mul_a;
    logic [IDX_W-1:0]  prod;
    logic [IDX_W-1:0]  i_ext;
    logic [IDX_W-1:0]  rx_ext;
    logic [IDX_W-1:0]  tl, tr, bl, br, e, s;
    logic [RES_W:0]    col_sum, row_sum;
    logic [RES_W:0]    col_inc;
    logic [RES_W-1:0]  len;

    assign emits = (cmd.mode == MODE_ADVANCE) && (section_reg != SEC_IDLE);

    assign step   = RES_W'(1) << lvl_reg;
    assign i_ext  = IDX_W'(col_reg);
    assign rx_ext = IDX_W'(geom.rx);
    assign mul_a  = (section_reg == SEC_MAIN) ? row_reg : col_reg;
    assign prod   = IDX_W'(mul_a) * rx_ext;

    assign lv_start   = (cmd.level > geom.lv_max) ? geom.lv_max : cmd.level;
    assign step_start = RES_W'(1) << lv_start;

    // Vertex indices for the triangle at the counters
    always_comb
    begin
        tl = prod + i_ext;
        tr = tl + IDX_W'(step);
        bl = tl + (rx_ext << lvl_reg);
        br = bl + IDX_W'(step);
        e  = '0;
        s  = '0;
        prim.part      = section_reg;
        prim.final_tri = (section_next == SEC_IDLE);
        prim.vert_first  = '0;
        prim.vert_second = '0;
        prim.vert_third  = '0;
        unique case (section_reg)
            SEC_MAIN:
            begin
                if (!half_reg) begin
                    prim.vert_first = tl; prim.vert_second = bl; prim.vert_third = tr;
                end else begin
                    prim.vert_first = tr; prim.vert_second = bl; prim.vert_third = br;
                end
            end
            SEC_BOTTOM:
            begin
                s = geom.mv + i_ext;
                if (!half_reg) begin
                    prim.vert_first = i_ext; prim.vert_second = s;
                    prim.vert_third = i_ext + IDX_W'(1);
                end else begin
                    prim.vert_first = i_ext + IDX_W'(1); prim.vert_second = s;
                    prim.vert_third = s + IDX_W'(1);
                end
            end
            SEC_TOP:
            begin
                e = geom.top_base + i_ext;
                s = geom.s_top + i_ext;
                if (!half_reg) begin
                    prim.vert_first = e; prim.vert_second = e + IDX_W'(1);
                    prim.vert_third = s;
                end else begin
                    prim.vert_first = e + IDX_W'(1); prim.vert_second = s + IDX_W'(1);
                    prim.vert_third = s;
                end
            end
            SEC_LEFT:
            begin
                e = prod;
                s = geom.s_left + i_ext;
                if (!half_reg) begin
                    prim.vert_first = e; prim.vert_second = s;
                    prim.vert_third = e + rx_ext;
                end else begin
                    prim.vert_first = e + rx_ext; prim.vert_second = s;
                    prim.vert_third = s + IDX_W'(1);
                end
            end
            SEC_RIGHT:
            begin
                e = prod + rx_ext - IDX_W'(1);
                s = geom.s_right + i_ext;
                if (!half_reg) begin
                    prim.vert_first = e; prim.vert_second = e + rx_ext;
                    prim.vert_third = s;
                end else begin
                    prim.vert_first = e + rx_ext; prim.vert_second = s + IDX_W'(1);
                    prim.vert_third = s;
                end
            end
            default:
            begin
                prim.part = section_reg;
            end
        endcase
    end

    // Counter advance
    always_comb
    begin
        lvl_next     = lvl_reg;
        section_next = section_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        half_next    = half_reg;
        col_sum = (RES_W+1)'(col_reg) + (RES_W+1)'(step);
        row_sum = (RES_W+1)'(row_reg) + (RES_W+1)'(step);
        col_inc = (RES_W+1)'(col_reg) + (RES_W+1)'(1);
        len     = (section_reg == SEC_BOTTOM || section_reg == SEC_TOP) ? geom.rx : geom.rz;
        if (cfg_clear) begin
            section_next = SEC_IDLE;
        end else if (step_en && cmd.mode == MODE_START) begin
            lvl_next  = lv_start;
            col_next  = '0;
            row_next  = '0;
            half_next = 1'b0;
            section_next = (step_start < geom.rx && step_start < geom.rz) ? SEC_MAIN
                                                                           : SEC_IDLE;
        end else if (step_en && emits) begin
            if (!half_reg) begin
                half_next = 1'b1;
            end else begin
                half_next = 1'b0;
                if (section_reg == SEC_MAIN) begin
                    if (col_sum + (RES_W+1)'(step) >= (RES_W+1)'(geom.rx)) begin
                        col_next = '0;
                        if (row_sum + (RES_W+1)'(step) >= (RES_W+1)'(geom.rz)) begin
                            row_next     = '0;
                            section_next = (lvl_reg == '0) ? SEC_BOTTOM : SEC_IDLE;
                        end else begin
                            row_next = row_sum[CNT_W-1:0];
                        end
                    end else begin
                        col_next = col_sum[CNT_W-1:0];
                    end
                end else begin
                    if (col_inc + (RES_W+1)'(1) >= (RES_W+1)'(len)) begin
                        col_next     = '0;
                        section_next = (section_reg == SEC_RIGHT) ? SEC_IDLE
                                                                  : section_reg + PART_W'(1);
                    end else begin
                        col_next = col_inc[CNT_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lvl_reg     <= '0;
            section_reg <= SEC_IDLE;
            col_reg     <= '0;
            row_reg     <= '0;
            half_reg    <= 1'b0;
        end else begin
            lvl_reg     <= lvl_next;
            section_reg <= section_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            half_reg    <= half_next;
        end
    end

endmodule

// ----- src/grid_lod_index_generator_top.sv -----
// Top level of the grid LOD index generator: request register, sequencer, result register.
// Path: an accepted request waits in the request register until the sequencer takes it;
//   an advance's triangle is then loaded into the result register, which drives prim.
// Throughput: one request per cycle while prim_ready stays high; the walk counters and index
//   adders of the sequencer update once per taken request, so one triangle leaves per cycle.
// Reset: rst_n clears the valid and sequencer registers at once; the list is idle, res_x and res_z read 2
//   and max_levels 1. No clearing pass.
module grid_lod_index_generator_top
    import gridlod_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_t                 cmd,
    // triangle channel
    output logic                 prim_valid,
    input  logic                 prim_ready,
    output prim_t                prim,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    geom_t geom;
    logic  cfg_clear;
    logic  emits;
    prim_t prim_calc;

    // Request register: holds the next request for the sequencer
    logic  req_valid_reg;
    cmd_t  req_reg;

    // Result register: parts the sequencer from the consumer
    logic  out_valid_reg;
    prim_t out_reg;

    logic  out_free;
    logic  req_go;

    // Configuration is always taken; the contract keeps writes to idle periods
    assign cfg_ready = 1'b1;

    gridlod_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_clear (cfg_clear),
        .geom      (geom)
    );

    gridlod_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .geom      (geom),
        .cfg_clear (cfg_clear),
        .step_en   (req_go),
        .cmd       (req_reg),
        .emits     (emits),
        .prim      (prim_calc)
    );

    // The result slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || prim_ready;
    // A request that yields no triangle never waits on the consumer
    assign req_go   = req_valid_reg && (!emits || out_free);
    // Take a new request whenever the held one moves on
    assign cmd_ready = !req_valid_reg || req_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd_ready)
                req_valid_reg <= cmd_valid;
            if (req_go && emits)
                out_valid_reg <= 1'b1;
            else if (prim_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers: load on handshake, otherwise hold
    always_ff @(posedge clk)
    begin
        if (cmd_ready && cmd_valid)
            req_reg <= cmd;
        if (req_go && emits)
            out_reg <= prim_calc;
    end

    assign prim_valid = out_valid_reg;
    assign prim       = out_reg;

    // A stalled request register only ever holds a live request
    a_stall_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> req_valid_reg)
        else $error("request channel stalled with no request held");

    // Every triangle carries a part of the grid, never the idle code
    a_part_range: assert property (@(posedge clk) disable iff (!rst_n)
        prim_valid |-> (prim.part == SEC_MAIN || prim.part == SEC_BOTTOM ||
                        prim.part == SEC_TOP || prim.part == SEC_LEFT ||
                        prim.part == SEC_RIGHT))
        else $error("triangle with an invalid part code");

    // A triangle never repeats a vertex
    a_distinct_verts: assert property (@(posedge clk) disable iff (!rst_n)
        prim_valid |-> (prim.vert_first != prim.vert_second &&
                        prim.vert_second != prim.vert_third &&
                        prim.vert_first != prim.vert_third))
        else $error("degenerate triangle emitted");

    // A triangle is loaded only when the held one leaves or the slot is empty
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !prim_ready) |=> $stable(out_reg))
        else $error("pending triangle overwritten");

endmodule
